[rtl/core/lob_pkg.sv]
package lob_pkg;

   // Default sizes of the book.
   localparam int PRICE_LEVELS_DEF = 1024;
   localparam int POOL_ORDERS_DEF  = 4096;

   // Item kinds.
   localparam logic [2:0] KIND_BUY      = 3'd0;
   localparam logic [2:0] KIND_SELL     = 3'd1;
   localparam logic [2:0] KIND_MKT_BUY  = 3'd2;
   localparam logic [2:0] KIND_MKT_SELL = 3'd3;
   localparam logic [2:0] KIND_SWEEP    = 3'd4;

   // Result status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_POOL    = 2'd1;
   localparam logic [1:0] ST_NO_BUY  = 2'd2;
   localparam logic [1:0] ST_NO_SELL = 2'd3;

   typedef enum logic [4:0] {
      S_CLR,
      S_IDLE,
      S_ADD_RD,
      S_ADD_WR,
      S_ADD_LINK,
      S_LV_RD,
      S_LV_CHK,
      S_PG_RD,
      S_PG_EV,
      S_FL_RD,
      S_FL_MUL,
      S_FL_ACC,
      S_LV_NEXT,
      S_BID_RD,
      S_BID_CHK,
      S_ASK_RD,
      S_ASK_CHK,
      S_DONE
   } state_type;

endpackage

[rtl/core/limit_order_book_matcher.sv]
// Steps: a limit add reads the free stack and the level pointers, writes the order, and for a
// tail append links the old tail; a market order visits levels, at each one purging expired
// resting orders and then filling from the head; a sweep visits every level and purges, then
// searches down for the best bid and up for the best ask. One item at a time; the result sits
// in an output register, so the next transfer is taken while it waits. Reset: synchronous; a
// clearing pass of the level lists and the free stack follows.
module limit_order_book_matcher #(
   parameter int PRICE_LEVELS = lob_pkg::PRICE_LEVELS_DEF,
   parameter int POOL_ORDERS  = lob_pkg::POOL_ORDERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [9:0]  req_price,
   input  logic [15:0] req_order_size,
   input  logic [47:0] req_expiry_time,
   input  logic [47:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_fill_cost,
   output logic [15:0] rsp_unfilled_size,
   output logic [9:0]  rsp_best_bid_out,
   output logic [10:0] rsp_best_ask_out,
   output logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import lob_pkg::*;

   localparam int IW    = $clog2(POOL_ORDERS);
   localparam int LW    = $clog2(POOL_ORDERS + 1);
   localparam int PLW   = $clog2(PRICE_LEVELS);
   localparam int AW    = $clog2(PRICE_LEVELS + 1);
   localparam int MW    = 16 + PLW;
   localparam int CLR_N = (POOL_ORDERS > PRICE_LEVELS) ? POOL_ORDERS : PRICE_LEVELS;
   localparam int CW    = $clog2(CLR_N);
   localparam logic [LW-1:0] NULL_LINK  = LW'(POOL_ORDERS);
   localparam logic [AW-1:0] NO_LEVEL   = AW'(PRICE_LEVELS);
   localparam logic [AW-1:0] LAST_LEVEL = AW'(PRICE_LEVELS - 1);
   localparam logic [CW-1:0] CLR_LAST   = CW'(CLR_N - 1);

   // Memories.
   logic [15:0]    qty_mem  [POOL_ORDERS];
   logic [47:0]    exp_mem  [POOL_ORDERS];
   logic [LW-1:0]  link_mem [POOL_ORDERS];
   logic [LW-1:0]  head_mem [PRICE_LEVELS];
   logic [LW-1:0]  tail_mem [PRICE_LEVELS];
   logic [IW-1:0]  fs_mem   [POOL_ORDERS];

   logic [15:0]    qty_rd_ff;
   logic [47:0]    exp_rd_ff;
   logic [LW-1:0]  link_rd_ff, head_rd_ff, tail_rd_ff;
   logic [IW-1:0]  fs_rd_ff;

   logic           qty_we, exp_we, link_we, head_we, tail_we, fs_we;
   logic [IW-1:0]  qty_wa, exp_wa, link_wa, fs_wa;
   logic [PLW-1:0] head_wa, tail_wa;
   logic [15:0]    qty_wd;
   logic [47:0]    exp_wd;
   logic [LW-1:0]  link_wd, head_wd, tail_wd;
   logic [IW-1:0]  fs_wd;
   logic [IW-1:0]  slot_ra, fs_ra;
   logic [PLW-1:0] lvl_ra;

   // Control and working registers.
   state_type      state_ff, state_in;
   logic [CW-1:0]  clr_ff, clr_in;
   logic [LW-1:0]  fc_ff, fc_in;
   logic [PLW-1:0] bid_ff, bid_in;
   logic [AW-1:0]  ask_ff, ask_in;
   logic           tie_ff;
   logic [2:0]     kind_ff, kind_in;
   logic [9:0]     price_ff, price_in;
   logic [15:0]    rem_ff, rem_in;
   logic [47:0]    expiry_ff, expiry_in;
   logic [47:0]    now_ff, now_in;
   logic [31:0]    cost_ff, cost_in;
   logic [31:0]    prod_ff, prod_in;
   logic [1:0]     status_ff, status_in;
   logic [AW-1:0]  lp_ff, lp_in;
   logic [LW-1:0]  lh_ff, lh_in, lt_ff, lt_in;
   logic [LW-1:0]  cur_ff, cur_in, prev_ff, prev_in;
   logic [LW-1:0]  guard_ff, guard_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic           full_ff, full_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_cost_ff, rsp_cost_in;
   logic [15:0]    rsp_unf_ff, rsp_unf_in;
   logic [9:0]     rsp_bid_ff, rsp_bid_in;
   logic [10:0]    rsp_ask_ff, rsp_ask_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;

   logic [PLW-1:0] price_idx, lvl_idx;
   logic [15:0]    take;
   logic [MW-1:0]  mul;
   logic [32:0]    sum;

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fill_cost     = rsp_cost_ff;
   assign rsp_unfilled_size = rsp_unf_ff;
   assign rsp_best_bid_out  = rsp_bid_ff;
   assign rsp_best_ask_out  = rsp_ask_ff;
   assign rsp_status        = rsp_status_ff;

   assign price_idx = PLW'(32'(price_ff));
   assign lvl_idx   = lp_ff[PLW-1:0];
   assign mul       = MW'(take) * MW'(lvl_idx);
   assign sum       = {1'b0, cost_ff} + {1'b0, prod_ff};

   // Memory ports: one write and one registered read per array.
   always_ff @(posedge clock) begin
      if (qty_we) qty_mem[qty_wa] <= qty_wd;
      if (exp_we) exp_mem[exp_wa] <= exp_wd;
      if (link_we) link_mem[link_wa] <= link_wd;
      if (head_we) head_mem[head_wa] <= head_wd;
      if (tail_we) tail_mem[tail_wa] <= tail_wd;
      if (fs_we) fs_mem[fs_wa] <= fs_wd;
      qty_rd_ff  <= qty_mem[slot_ra];
      exp_rd_ff  <= exp_mem[slot_ra];
      link_rd_ff <= link_mem[slot_ra];
      head_rd_ff <= head_mem[lvl_ra];
      tail_rd_ff <= tail_mem[lvl_ra];
      fs_rd_ff   <= fs_mem[fs_ra];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         fc_ff        <= NULL_LINK;
         bid_ff       <= '0;
         ask_ff       <= NO_LEVEL;
         tie_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fc_ff        <= fc_in;
         bid_ff       <= bid_in;
         ask_ff       <= ask_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            tie_ff <= csr_wr_data;
         end
      end
   end

   // Working payload.
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      price_ff      <= price_in;
      rem_ff        <= rem_in;
      expiry_ff     <= expiry_in;
      now_ff        <= now_in;
      cost_ff       <= cost_in;
      prod_ff       <= prod_in;
      status_ff     <= status_in;
      lp_ff         <= lp_in;
      lh_ff         <= lh_in;
      lt_ff         <= lt_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      guard_ff      <= guard_in;
      idx_ff        <= idx_in;
      full_ff       <= full_in;
      rsp_cost_ff   <= rsp_cost_in;
      rsp_unf_ff    <= rsp_unf_in;
      rsp_bid_ff    <= rsp_bid_in;
      rsp_ask_ff    <= rsp_ask_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      fc_in         = fc_ff;
      bid_in        = bid_ff;
      ask_in        = ask_ff;
      kind_in       = kind_ff;
      price_in      = price_ff;
      rem_in        = rem_ff;
      expiry_in     = expiry_ff;
      now_in        = now_ff;
      cost_in       = cost_ff;
      prod_in       = prod_ff;
      status_in     = status_ff;
      lp_in         = lp_ff;
      lh_in         = lh_ff;
      lt_in         = lt_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      guard_in      = guard_ff;
      idx_in        = idx_ff;
      full_in       = full_ff;
      rsp_cost_in   = rsp_cost_ff;
      rsp_unf_in    = rsp_unf_ff;
      rsp_bid_in    = rsp_bid_ff;
      rsp_ask_in    = rsp_ask_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      take          = '0;
      qty_we = 1'b0; qty_wa = cur_ff[IW-1:0]; qty_wd = rem_ff;
      exp_we = 1'b0; exp_wa = cur_ff[IW-1:0]; exp_wd = expiry_ff;
      link_we = 1'b0; link_wa = cur_ff[IW-1:0]; link_wd = NULL_LINK;
      head_we = 1'b0; head_wa = lvl_idx; head_wd = NULL_LINK;
      tail_we = 1'b0; tail_wa = lvl_idx; tail_wd = NULL_LINK;
      fs_we = 1'b0; fs_wa = fc_ff[IW-1:0]; fs_wd = cur_ff[IW-1:0];
      slot_ra = cur_ff[IW-1:0];
      lvl_ra  = lvl_idx;
      fs_ra   = IW'(fc_ff - LW'(1));

      unique case (state_ff)
         // Clear the level lists and load the free stack after reset.
         S_CLR: begin
            if (32'(clr_ff) < 32'(PRICE_LEVELS)) begin
               head_we = 1'b1; head_wa = PLW'(clr_ff); head_wd = NULL_LINK;
               tail_we = 1'b1; tail_wa = PLW'(clr_ff); tail_wd = NULL_LINK;
            end
            if (32'(clr_ff) < 32'(POOL_ORDERS)) begin
               fs_we = 1'b1; fs_wa = IW'(clr_ff); fs_wd = IW'(clr_ff);
            end
            clr_in = clr_ff + CW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         // Take one input transfer.
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               price_in  = req_price;
               rem_in    = req_order_size;
               expiry_in = req_expiry_time;
               now_in    = req_now_time;
               cost_in   = '0;
               status_in = ST_OK;
               priority case (req_kind)
                  KIND_BUY, KIND_SELL: begin
                     if (32'(req_price) >= 32'(PRICE_LEVELS)) begin
                        state_in = S_DONE;
                     end else if (fc_ff == '0) begin
                        status_in = ST_POOL;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_ADD_RD;
                     end
                  end
                  KIND_MKT_BUY: begin
                     lp_in    = ask_ff;
                     state_in = S_LV_RD;
                  end
                  KIND_MKT_SELL: begin
                     lp_in    = AW'(bid_ff);
                     state_in = S_LV_RD;
                  end
                  KIND_SWEEP: begin
                     lp_in    = '0;
                     state_in = S_LV_RD;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         // Limit add: fetch a free slot and the level pointers.
         S_ADD_RD: begin
            lvl_ra   = price_idx;
            state_in = S_ADD_WR;
         end
         S_ADD_WR: begin
            fc_in  = fc_ff - LW'(1);
            idx_in = fs_rd_ff;
            lt_in  = tail_rd_ff;
            qty_we = 1'b1; qty_wa = fs_rd_ff; qty_wd = rem_ff;
            exp_we = 1'b1; exp_wa = fs_rd_ff; exp_wd = expiry_ff;
            link_we = 1'b1; link_wa = fs_rd_ff;
            link_wd = (head_rd_ff < NULL_LINK && tie_ff) ? head_rd_ff : NULL_LINK;
            head_wa = price_idx;
            tail_wa = price_idx;
            state_in = S_DONE;
            if (head_rd_ff >= NULL_LINK) begin
               head_we = 1'b1; head_wd = LW'(fs_rd_ff);
               tail_we = 1'b1; tail_wd = LW'(fs_rd_ff);
            end else if (tie_ff) begin
               head_we = 1'b1; head_wd = LW'(fs_rd_ff);
            end else begin
               tail_we  = 1'b1; tail_wd = LW'(fs_rd_ff);
               state_in = S_ADD_LINK;
            end
            if (kind_ff == KIND_BUY) begin
               if (32'(price_ff) > 32'(bid_ff)) bid_in = price_idx;
            end else begin
               if (32'(price_ff) < 32'(ask_ff)) ask_in = AW'(32'(price_ff));
            end
         end
         S_ADD_LINK: begin
            if (lt_ff < NULL_LINK) begin
               link_we = 1'b1; link_wa = lt_ff[IW-1:0]; link_wd = LW'(idx_ff);
            end
            state_in = S_DONE;
         end
         // Top of the level walk.
         S_LV_RD: begin
            if (kind_ff != KIND_SWEEP && rem_ff == '0) begin
               state_in = S_DONE;
            end else if (lp_ff >= NO_LEVEL) begin
               if (kind_ff == KIND_MKT_BUY) begin
                  status_in = ST_NO_SELL;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_LV_NEXT;
               end
            end else begin
               state_in = S_LV_CHK;
            end
         end
         S_LV_CHK: begin
            if (head_rd_ff < NULL_LINK) begin
               if (kind_ff == KIND_MKT_BUY) ask_in = lp_ff;
               if (kind_ff == KIND_MKT_SELL) bid_in = lvl_idx;
               lh_in    = head_rd_ff;
               lt_in    = tail_rd_ff;
               cur_in   = head_rd_ff;
               prev_in  = NULL_LINK;
               guard_in = '0;
               state_in = S_PG_RD;
            end else begin
               state_in = S_LV_NEXT;
            end
         end
         // Expiry purge: read, then evaluate, each resting order in turn.
         S_PG_RD: begin
            if (cur_ff < NULL_LINK && guard_ff < NULL_LINK) begin
               guard_in = guard_ff + LW'(1);
               state_in = S_PG_EV;
            end else begin
               guard_in = '0;
               state_in = (kind_ff == KIND_SWEEP) ? S_LV_NEXT : S_FL_RD;
            end
         end
         S_PG_EV: begin
            if (exp_rd_ff <= now_ff) begin
               if (prev_ff >= NULL_LINK) begin
                  head_we = 1'b1; head_wd = link_rd_ff;
                  lh_in   = link_rd_ff;
               end else begin
                  link_we = 1'b1; link_wa = prev_ff[IW-1:0]; link_wd = link_rd_ff;
               end
               if (lt_ff == cur_ff) begin
                  tail_we = 1'b1; tail_wd = prev_ff;
                  lt_in   = prev_ff;
               end
               if (fc_ff < NULL_LINK) begin
                  fs_we = 1'b1;
                  fc_in = fc_ff + LW'(1);
               end
            end else begin
               prev_in = cur_ff;
            end
            cur_in   = link_rd_ff;
            state_in = S_PG_RD;
         end
         // Fill from the head of the level; oldest first unless tie_ff puts new orders at the head.
         S_FL_RD: begin
            slot_ra = lh_ff[IW-1:0];
            if (lh_ff < NULL_LINK && guard_ff < NULL_LINK) begin
               guard_in = guard_ff + LW'(1);
               state_in = S_FL_MUL;
            end else begin
               state_in = S_LV_NEXT;
            end
         end
         S_FL_MUL: begin
            if (rem_ff >= qty_rd_ff) begin
               take    = qty_rd_ff;
               rem_in  = rem_ff - qty_rd_ff;
               full_in = 1'b1;
               head_we = 1'b1;
               if (link_rd_ff >= NULL_LINK) begin
                  head_wd = NULL_LINK;
                  lh_in   = NULL_LINK;
                  tail_we = 1'b1; tail_wd = NULL_LINK;
                  lt_in   = NULL_LINK;
               end else begin
                  head_wd = link_rd_ff;
                  lh_in   = link_rd_ff;
               end
               if (fc_ff < NULL_LINK) begin
                  fs_we = 1'b1; fs_wd = lh_ff[IW-1:0];
                  fc_in = fc_ff + LW'(1);
               end
            end else begin
               take    = rem_ff;
               rem_in  = '0;
               full_in = 1'b0;
               qty_we  = 1'b1; qty_wa = lh_ff[IW-1:0]; qty_wd = qty_rd_ff - rem_ff;
            end
            prod_in  = 32'(mul);
            state_in = S_FL_ACC;
         end
         S_FL_ACC: begin
            cost_in  = sum[32] ? '1 : sum[31:0];
            state_in = full_ff ? S_FL_RD : S_LV_NEXT;
         end
         // Step to the next level.
         S_LV_NEXT: begin
            priority case (kind_ff)
               KIND_MKT_BUY: begin
                  lp_in    = lp_ff + AW'(1);
                  state_in = S_LV_RD;
               end
               KIND_MKT_SELL: begin
                  if (lp_ff == '0) begin
                     if (rem_ff != '0) status_in = ST_NO_BUY;
                     state_in = S_DONE;
                  end else begin
                     lp_in    = lp_ff - AW'(1);
                     state_in = S_LV_RD;
                  end
               end
               default: begin
                  if (lp_ff >= LAST_LEVEL) begin
                     lp_in    = AW'(bid_ff);
                     state_in = S_BID_RD;
                  end else begin
                     lp_in    = lp_ff + AW'(1);
                     state_in = S_LV_RD;
                  end
               end
            endcase
         end
         // Sweep: search down for the best bid.
         S_BID_RD: begin
            state_in = S_BID_CHK;
         end
         S_BID_CHK: begin
            if (lp_ff < NO_LEVEL && head_rd_ff < NULL_LINK) begin
               bid_in   = lvl_idx;
               lp_in    = ask_ff;
               state_in = S_ASK_RD;
            end else if (lp_ff == '0) begin
               bid_in    = '0;
               status_in = ST_NO_BUY;
               lp_in     = ask_ff;
               state_in  = S_ASK_RD;
            end else begin
               lp_in    = lp_ff - AW'(1);
               state_in = S_BID_RD;
            end
         end
         // Sweep: search up for the best ask.
         S_ASK_RD: begin
            if (lp_ff >= NO_LEVEL) begin
               ask_in = NO_LEVEL;
               if (status_ff != ST_NO_BUY) status_in = ST_NO_SELL;
               state_in = S_DONE;
            end else begin
               state_in = S_ASK_CHK;
            end
         end
         S_ASK_CHK: begin
            if (head_rd_ff < NULL_LINK) begin
               ask_in   = lp_ff;
               state_in = S_DONE;
            end else begin
               lp_in    = lp_ff + AW'(1);
               state_in = S_ASK_RD;
            end
         end
         // Hand the result to the output register.
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_cost_in   = cost_ff;
               rsp_unf_in    = (kind_ff == KIND_MKT_BUY || kind_ff == KIND_MKT_SELL) ?
                               rem_ff : '0;
               rsp_bid_in    = 10'(bid_ff);
               rsp_ask_in    = 11'(ask_ff);
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The free count never exceeds the pool.
   a_fc_bound: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= NULL_LINK) else $error("free count above pool size");

   // A new result only appears out of the hand-off state.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside hand-off");

   // Reset always starts the clearing pass.
   a_reset_clr: assert property (@(posedge clock)
      $past(reset) |-> state_ff == S_CLR) else $error("no clearing pass after reset");

   // A pool-empty result carries no cost.
   a_pool_cost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_POOL) |-> rsp_cost_ff == '0)
      else $error("cost on pool-empty result");

   // A limit add takes exactly one slot from the free stack.
   a_add_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ADD_WR |=> fc_ff == $past(fc_ff) - LW'(1))
      else $error("limit add did not take one slot");

endmodule
